// ----- hdl/motion_axis_lock_assert.svh -----
// Assertion macros for the motion axis lock RTL.
`ifndef MOTION_AXIS_LOCK_ASSERT_SVH
`define MOTION_AXIS_LOCK_ASSERT_SVH

// Same-cycle implication.
`define MAL_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define MAL_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/mal_pkg.sv -----
`timescale 1ns / 1ps

package mal_pkg;

	localparam logic [1:0] CMD_X    = 2'd0;
	localparam logic [1:0] CMD_Y    = 2'd1;
	localparam logic [1:0] CMD_PASS = 2'd2;

	localparam logic [1:0] REG_STEP_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_RELEASE_TIME   = 2'd1;
	localparam logic [1:0] REG_VERTICAL_BIAS  = 2'd2;

	localparam logic [15:0] STEP_THRESHOLD_RST = 16'd20;
	localparam logic [15:0] RELEASE_TIME_RST   = 16'd200;
	localparam logic [15:0] VERTICAL_BIAS_RST  = 16'd1000;

	localparam logic [9:0] BIAS_SCALE = 10'd1000;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] motion_value;
		logic [31:0]        time_ms;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic signed [31:0] out_value;
	} out_beat_t;

	typedef enum logic [1:0] {
		LOCK_FREE,
		LOCK_X,
		LOCK_Y
	} lock_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RELEASE,
		ST_ADD,
		ST_MAG,
		ST_DECIDE,
		ST_SEL,
		ST_DIV,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic load_in;
		logic pass;
		logic release_chk;
		logic add;
		logic mag;
		logic decide;
		logic sel;
		logic finish;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic passthru;
		logic locked;
		logic below;
		logic div_busy;
	} sts_t;

endpackage

// ----- hdl/motion_axis_lock.sv -----
// Passthrough beats run RELEASE, EMIT; motion below the lock level RELEASE, ADD, MAG,
// DECIDE, EMIT; motion that emits units RELEASE, ADD, MAG, SEL, DIV, EMIT, with DECIDE
// after MAG when it takes the lock. The 32-step serial divider sets the motion rate.
// A new beat is taken in IDLE only, once the last one is done, and while its result waits.
// Reset (arst_n, async, active low): accumulators, lock, last time and the seen flag
// clear, registers return to threshold 20, release 200 ms, bias 1000.
`timescale 1ns / 1ps

module motion_axis_lock (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mal_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mal_pkg::out_beat_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [15:0]   step_threshold_q;
	logic [15:0]   release_time_q;
	logic [15:0]   vertical_bias_q;
	mal_pkg::ctl_t ctl;
	mal_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_threshold_q <= mal_pkg::STEP_THRESHOLD_RST;
			release_time_q   <= mal_pkg::RELEASE_TIME_RST;
			vertical_bias_q  <= mal_pkg::VERTICAL_BIAS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mal_pkg::REG_STEP_THRESHOLD: step_threshold_q <= cfg_data;
				mal_pkg::REG_RELEASE_TIME:   release_time_q   <= cfg_data;
				mal_pkg::REG_VERTICAL_BIAS:  vertical_bias_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	mal_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (in_data),
		.step_threshold(step_threshold_q),
		.release_time  (release_time_q),
		.vertical_bias (vertical_bias_q),
		.ctl           (ctl),
		.sts           (sts),
		.out_data      (out_data)
	);

endmodule

// ----- hdl/mal_div.sv -----
`timescale 1ns / 1ps

module mal_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [31:0] quotient,
	output logic [15:0] remainder
);

	logic [mal_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [15:0]                   div_q;
	logic [15:0]                   rem_q;
	logic [31:0]                   quo_q;
	logic [16:0]                   trial;
	logic [16:0]                   diff;
	logic                          fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= mal_pkg::DIV_CNT_W'(mal_pkg::DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- hdl/mal_dp.sv -----
`timescale 1ns / 1ps
`include "motion_axis_lock_assert.svh"

module mal_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mal_pkg::in_beat_t  in_data,
	input  logic [15:0]        step_threshold,
	input  logic [15:0]        release_time,
	input  logic [15:0]        vertical_bias,
	input  mal_pkg::ctl_t      ctl,
	output mal_pkg::sts_t      sts,
	output mal_pkg::out_beat_t out_data
);

	logic [1:0]         cmd_q;
	logic signed [15:0] val_q;
	logic [31:0]        time_q;

	logic signed [31:0] acc_x_q;
	logic signed [31:0] acc_y_q;
	mal_pkg::lock_t     lock_q;
	logic [31:0]        last_time_q;
	logic               seen_q;

	logic [47:0]        py_q;
	logic [41:0]        ax_q;
	logic [25:0]        thr_q;
	logic               neg_q;
	mal_pkg::out_beat_t res_q;
	mal_pkg::out_beat_t out_q;

	logic [15:0]        thr;
	logic [31:0]        gap;
	logic               expired;
	logic [31:0]        mag_x;
	logic [31:0]        mag_y;
	logic signed [31:0] add_acc;
	logic signed [32:0] sum;
	logic signed [31:0] sat_sum;
	logic signed [31:0] lock_acc;
	logic [31:0]        lock_mag;
	logic               div_busy;
	logic [31:0]        quo;
	logic [15:0]        rem;
	logic [31:0]        rem_ext;
	logic [31:0]        q_signed;
	logic [31:0]        acc_rem;

	assign thr     = (step_threshold == 16'd0) ? 16'd1 : step_threshold;
	assign gap     = time_q - last_time_q;
	assign expired = seen_q && (gap > {16'd0, release_time});
	assign mag_x   = acc_x_q[31] ? 32'(-acc_x_q) : 32'(acc_x_q);
	assign mag_y   = acc_y_q[31] ? 32'(-acc_y_q) : 32'(acc_y_q);

	assign add_acc = (cmd_q == mal_pkg::CMD_Y) ? acc_y_q : acc_x_q;
	assign sum     = {add_acc[31], add_acc} + 33'(val_q);
	always_comb begin
		if (sum[32] != sum[31]) begin
			sat_sum = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_sum = sum[31:0];
		end
	end

	assign lock_acc = (lock_q == mal_pkg::LOCK_Y) ? acc_y_q : acc_x_q;
	assign lock_mag = (lock_q == mal_pkg::LOCK_Y) ? mag_y : mag_x;
	assign rem_ext  = {16'd0, rem};
	assign q_signed = neg_q ? (~quo + 32'd1) : quo;
	assign acc_rem  = neg_q ? (~rem_ext + 32'd1) : rem_ext;

	mal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.sel),
		.dividend (lock_mag),
		.divisor  (thr),
		.busy     (div_busy),
		.quotient (quo),
		.remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			lock_q      <= mal_pkg::LOCK_FREE;
			last_time_q <= '0;
			seen_q      <= 1'b0;
		end else begin
			if (ctl.release_chk) begin
				if (expired) begin
					acc_x_q <= '0;
					acc_y_q <= '0;
					lock_q  <= mal_pkg::LOCK_FREE;
				end
				last_time_q <= time_q;
				seen_q      <= 1'b1;
			end
			if (ctl.add) begin
				if (cmd_q == mal_pkg::CMD_Y) begin
					acc_y_q <= sat_sum;
				end else begin
					acc_x_q <= sat_sum;
				end
			end
			if (ctl.decide && !sts.below) begin
				lock_q <= ({6'd0, ax_q} <= py_q) ? mal_pkg::LOCK_Y : mal_pkg::LOCK_X;
			end
			if (ctl.sel) begin
				if (lock_q == mal_pkg::LOCK_Y) begin
					acc_x_q <= '0;
				end else begin
					acc_y_q <= '0;
				end
			end
			if (ctl.finish) begin
				if (lock_q == mal_pkg::LOCK_Y) begin
					acc_y_q <= acc_rem;
				end else begin
					acc_x_q <= acc_rem;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= in_data.command;
			val_q  <= in_data.motion_value;
			time_q <= in_data.time_ms;
		end
		if (ctl.mag) begin
			py_q  <= mag_y * vertical_bias;
			ax_q  <= mag_x * mal_pkg::BIAS_SCALE;
			thr_q <= thr * mal_pkg::BIAS_SCALE;
		end
		if (ctl.sel) begin
			neg_q <= lock_acc[31];
		end
		if (ctl.pass) begin
			res_q.out_kind  <= mal_pkg::CMD_PASS;
			res_q.out_value <= 32'(val_q);
		end
		if (ctl.decide && sts.below) begin
			res_q.out_kind  <= cmd_q;
			res_q.out_value <= '0;
		end
		if (ctl.finish) begin
			res_q.out_kind  <= (lock_q == mal_pkg::LOCK_Y) ? mal_pkg::CMD_Y : mal_pkg::CMD_X;
			res_q.out_value <= q_signed;
		end
		if (ctl.load_out) begin
			out_q <= res_q;
		end
	end

	assign sts.passthru = cmd_q[1];
	assign sts.locked   = (lock_q == mal_pkg::LOCK_X) || (lock_q == mal_pkg::LOCK_Y);
	assign sts.below    = (py_q < {22'd0, thr_q}) && (ax_q < {16'd0, thr_q});
	assign sts.div_busy = div_busy;
	assign out_data     = out_q;

	`MAL_ASSERT_IMP(a_sel_locked, clk, arst_n, ctl.sel,
		(lock_q == mal_pkg::LOCK_X) || (lock_q == mal_pkg::LOCK_Y),
		"divide started without an axis lock")
	`MAL_ASSERT_NXT(a_sel_busy, clk, arst_n, ctl.sel, div_busy,
		"divider did not start")
	`MAL_ASSERT_IMP(a_other_zero, clk, arst_n, ctl.finish,
		((lock_q == mal_pkg::LOCK_Y) && (acc_x_q == '0)) ||
		((lock_q == mal_pkg::LOCK_X) && (acc_y_q == '0)),
		"unlocked axis accumulator not cleared")
	`MAL_ASSERT_IMP(a_rem_range, clk, arst_n, ctl.finish, rem < thr,
		"remainder not below threshold")

endmodule

// ----- hdl/mal_ctrl.sv -----
`timescale 1ns / 1ps

module mal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mal_pkg::sts_t sts,
	output mal_pkg::ctl_t ctl
);

	mal_pkg::st_t state_q;
	mal_pkg::st_t state_d;
	logic         out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mal_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			mal_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = mal_pkg::ST_RELEASE;
				end
			end
			mal_pkg::ST_RELEASE: begin
				if (sts.passthru) begin
					ctl.pass = 1'b1;
					state_d  = mal_pkg::ST_EMIT;
				end else begin
					ctl.release_chk = 1'b1;
					state_d         = mal_pkg::ST_ADD;
				end
			end
			mal_pkg::ST_ADD: begin
				ctl.add = 1'b1;
				state_d = mal_pkg::ST_MAG;
			end
			mal_pkg::ST_MAG: begin
				ctl.mag = 1'b1;
				state_d = sts.locked ? mal_pkg::ST_SEL : mal_pkg::ST_DECIDE;
			end
			mal_pkg::ST_DECIDE: begin
				ctl.decide = 1'b1;
				state_d    = sts.below ? mal_pkg::ST_EMIT : mal_pkg::ST_SEL;
			end
			mal_pkg::ST_SEL: begin
				ctl.sel = 1'b1;
				state_d = mal_pkg::ST_DIV;
			end
			mal_pkg::ST_DIV: begin
				if (!sts.div_busy) begin
					ctl.finish = 1'b1;
					state_d    = mal_pkg::ST_EMIT;
				end
			end
			mal_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = mal_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mal_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] CMD_OTHER = 2'd3;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_ITEMS = 240;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	mal_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mal_pkg::out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = mal_pkg::REG_STEP_THRESHOLD;
	logic [15:0] cfg_data = '0;

	motion_axis_lock DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// lock state and registers as they stand after reset
	logic [15:0] m_thr = mal_pkg::STEP_THRESHOLD_RST;
	logic [15:0] m_rel = mal_pkg::RELEASE_TIME_RST;
	logic [15:0] m_bias = mal_pkg::VERTICAL_BIAS_RST;
	logic signed [31:0] m_acc_x = '0;
	logic signed [31:0] m_acc_y = '0;
	mal_pkg::lock_t m_lock = mal_pkg::LOCK_FREE;
	logic [31:0] m_last_ms = '0;
	logic m_seen = 1'b0;

	typedef struct {
		mal_pkg::in_beat_t beat;
		bit fixed;
		mal_pkg::out_beat_t want;
	} dir_row_t;

	dir_row_t dir_rows[$];
	mal_pkg::out_beat_t motion_out_q[$];
	int errors = 0;
	bit calm = 1'b0;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < 64'shFFFF_FFFF_8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return (w < 0) ? -w : w;
	endfunction

	function automatic mal_pkg::out_beat_t locked_motion(input mal_pkg::in_beat_t b);
		mal_pkg::out_beat_t r;
		logic signed [15:0] d;
		logic signed [63:0] wide, q, thr_s;
		logic [63:0] thr, ax, ay;
		logic [31:0] gap_ms;
		d = b.motion_value;
		thr = (m_thr == 16'd0) ? 64'd1 : {48'd0, m_thr};
		thr_s = thr;
		if (b.command != mal_pkg::CMD_X && b.command != mal_pkg::CMD_Y) begin
			r.out_kind = mal_pkg::CMD_PASS;
			r.out_value = 32'(d);
			return r;
		end
		gap_ms = b.time_ms - m_last_ms;
		if (m_seen && gap_ms > {16'd0, m_rel}) begin
			m_acc_x = '0;
			m_acc_y = '0;
			m_lock = mal_pkg::LOCK_FREE;
		end
		m_last_ms = b.time_ms;
		m_seen = 1'b1;
		if (b.command == mal_pkg::CMD_X) begin
			wide = 64'(m_acc_x);
			m_acc_x = sat32(wide + d);
		end else begin
			wide = 64'(m_acc_y);
			m_acc_y = sat32(wide + d);
		end
		if (m_lock == mal_pkg::LOCK_FREE) begin
			ax = mag64(m_acc_x);
			ay = mag64(m_acc_y) * m_bias / mal_pkg::BIAS_SCALE;
			if (ax < thr && ay < thr) begin
				r.out_kind = b.command;
				r.out_value = '0;
				return r;
			end
			m_lock = (ay >= ax) ? mal_pkg::LOCK_Y : mal_pkg::LOCK_X;
		end
		if (m_lock == mal_pkg::LOCK_Y) begin
			m_acc_x = '0;
			wide = 64'(m_acc_y);
			q = wide / thr_s;
			m_acc_y = 32'(wide - q * thr_s);
			r.out_kind = mal_pkg::CMD_Y;
		end else begin
			m_acc_y = '0;
			wide = 64'(m_acc_x);
			q = wide / thr_s;
			m_acc_x = 32'(wide - q * thr_s);
			r.out_kind = mal_pkg::CMD_X;
		end
		r.out_value = q[31:0];
		return r;
	endfunction

	function automatic dir_row_t row(input logic [1:0] cmd, input logic [15:0] val,
		input logic [31:0] ms, input bit fixed, input logic [1:0] kind, input logic [31:0] outv);
		dir_row_t x;
		x.beat.command = cmd;
		x.beat.motion_value = val;
		x.beat.time_ms = ms;
		x.fixed = fixed;
		x.want.out_kind = kind;
		x.want.out_value = outv;
		return x;
	endfunction

	function automatic void check_result(input mal_pkg::out_beat_t got);
		mal_pkg::out_beat_t want;
		if (motion_out_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected beat, expected none, got kind %0d value %0d",
				$time, got.out_kind, got.out_value);
		end else begin
			want = motion_out_q.pop_front();
			if (got.out_kind !== want.out_kind) begin
				errors++;
				$display("%0t: out_kind expected %0d got %0d", $time, want.out_kind, got.out_kind);
			end
			if (got.out_value !== want.out_value) begin
				errors++;
				$display("%0t: out_value expected %0d got %0d",
					$time, want.out_value, got.out_value);
			end
		end
	endfunction

	task automatic load_regs(input logic [15:0] thr, input logic [15:0] rel,
		input logic [15:0] bias);
		cfg_we <= 1'b1;
		cfg_index <= mal_pkg::REG_STEP_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		m_thr = thr;
		cfg_index <= mal_pkg::REG_RELEASE_TIME;
		cfg_data <= rel;
		@(posedge clk);
		m_rel = rel;
		cfg_index <= mal_pkg::REG_VERTICAL_BIAS;
		cfg_data <= bias;
		@(posedge clk);
		m_bias = bias;
		// unused index, must be dropped
		cfg_index <= REG_NONE;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_beat(input mal_pkg::in_beat_t b, input bit fixed,
		input mal_pkg::out_beat_t want);
		int gap;
		mal_pkg::out_beat_t pred;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		pred = locked_motion(b);
		motion_out_q.push_back(fixed ? want : pred);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (motion_out_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		mal_pkg::in_beat_t b;
		mal_pkg::out_beat_t none;
		logic [31:0] ts;
		logic [1:0] lead;
		int span, roll, v;
		none = '0;
		ts = $urandom;
		lead = mal_pkg::CMD_X;
		span = 3 * ((m_thr == 16'd0) ? 1 : int'(m_thr));
		if (span > 32767)
			span = 32767;
		for (int i = 0; i < count; i++) begin
			calm = ((i / 40) % 4) == 3;
			if (i % 20 == 0)
				lead = $urandom_range(0, 1) ? mal_pkg::CMD_Y : mal_pkg::CMD_X;
			roll = $urandom_range(0, 99);
			b.motion_value = 16'($urandom);
			b.time_ms = $urandom;
			if (roll < 6) begin
				b.command = $urandom_range(0, 1) ? mal_pkg::CMD_PASS : CMD_OTHER;
			end else if (roll < 12) begin
				b.command = $urandom_range(0, 1) ? mal_pkg::CMD_Y : mal_pkg::CMD_X;
			end else begin
				// gesture: mostly the leading axis, timestamps close together
				b.command = ($urandom_range(0, 3) == 0) ?
					((lead == mal_pkg::CMD_X) ? mal_pkg::CMD_Y : mal_pkg::CMD_X) : lead;
				if (roll >= 20) begin
					v = $urandom_range(0, 2 * span);
					b.motion_value = 16'(v - span);
				end
				if ($urandom_range(0, 19) == 0)
					ts = ts + m_rel + 1 + $urandom_range(0, 50);
				else
					ts = ts + $urandom_range(0, m_rel);
				b.time_ms = ts;
			end
			send_beat(b, 1'b0, none);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(row(mal_pkg::CMD_PASS, 16'h7FFF, 32'h0000_0000, 1,
			mal_pkg::CMD_PASS, 32'h0000_7FFF));
		dir_rows.push_back(row(CMD_OTHER, 16'h8000, 32'h0000_0000, 1,
			mal_pkg::CMD_PASS, 32'hFFFF_8000));
		dir_rows.push_back(row(mal_pkg::CMD_PASS, 16'hFFFF, 32'hFFFF_FFFF, 1,
			mal_pkg::CMD_PASS, 32'hFFFF_FFFF));
		// first motion with a far timestamp: no release
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'd5, 32'hFFFF_FFF0, 1, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'd3, 32'hFFFF_FFF8, 1, mal_pkg::CMD_Y, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'd20, 32'hFFFF_FFFF, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'd100, 32'h0000_0010, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_PASS, 16'h1234, 32'h0000_0000, 1,
			mal_pkg::CMD_PASS, 32'h0000_1234));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'h8000, 32'h0000_0020, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'h7FFF, 32'h0000_0030, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'hFFFF, 32'h0000_0030, 0, mal_pkg::CMD_X, 32'd0));
		// gap of one past the release time
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'd1, 32'h0000_00F9, 1, mal_pkg::CMD_X, 32'd0));
		// gap of exactly the release time
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'd10, 32'h0000_01C1, 1, mal_pkg::CMD_Y, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'd10, 32'h0000_01C1, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'h7FFF, 32'h0000_01C2, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'hFFD3, 32'h0000_01C3, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'h8000, 32'h0000_01C4, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'h7FFF, 32'hFFFF_0000, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'd19, 32'hFFFF_0400, 1, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_Y, 16'd19, 32'hFFFF_0401, 1, mal_pkg::CMD_Y, 32'd0));
		dir_rows.push_back(row(mal_pkg::CMD_X, 16'd1, 32'hFFFF_0402, 0, mal_pkg::CMD_X, 32'd0));
		dir_rows.push_back(row(CMD_OTHER, 16'h0000, 32'hFFFF_0403, 1, mal_pkg::CMD_PASS, 32'd0));

		foreach (dir_rows[k])
			send_beat(dir_rows[k].beat, dir_rows[k].fixed, dir_rows[k].want);
		settle();

		load_regs(16'd0, 16'd0, 16'd0);
		send_random(PHASE_ITEMS);
		settle();
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_random(PHASE_ITEMS);
		settle();
		load_regs(16'd1, 16'hFFFF, 16'd1000);
		send_random(PHASE_ITEMS);
		settle();
		load_regs(mal_pkg::STEP_THRESHOLD_RST, mal_pkg::RELEASE_TIME_RST,
			mal_pkg::VERTICAL_BIAS_RST);
		send_random(PHASE_ITEMS);
		settle();
		for (int p = 0; p < 4; p++) begin
			if (p < 2)
				load_regs(16'($urandom_range(1, 100)), 16'($urandom_range(0, 1000)),
					16'($urandom_range(0, 3000)));
			else
				load_regs(16'($urandom), 16'($urandom), 16'($urandom));
			send_random(PHASE_ITEMS);
			settle();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			check_result(out_data);
	end

	initial begin
		int unsigned cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
